// File: design/bmvp_pkg.sv
// Package for the batched matrix-vector product block.
// Holds the fixed field widths, register indexes and the pipeline tag type.
// No dependencies.
package bmvp_pkg;

  // Fixed widths of the payload and configuration words
  localparam int unsigned ElemW   = 16;
  localparam int unsigned ProdW   = 2 * ElemW;
  localparam int unsigned AccW    = 48;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned RowOutW = 10;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_VECTOR_LENGTH = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT = 1'd1;

  // Saturation bounds of the accumulator
  localparam logic signed [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};

  // Tag that travels with a matrix word down the MAC pipeline
  typedef struct packed {
    logic                      valid;
    logic                      row_end;
    logic                      last;
    logic [RowOutW-1:0]        row_index;
    logic signed [ElemW-1:0]   element;
  } mac_tag_t;

endpackage

// File: design/bmvp_vector_store.sv
// Vector store: single-port synchronous memory with a registered read port.
// Depends on bmvp_pkg for the element width.
module bmvp_vector_store import bmvp_pkg::*; #(
  parameter int unsigned Depth = 1024
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   addr_i,
  input  logic signed [ElemW-1:0]    wdata_i,
  output logic signed [ElemW-1:0]    rdata_o
);

  logic signed [ElemW-1:0] mem [Depth];

  // Write one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

// File: design/bmvp_sequencer.sv
// Sequencer: configuration registers, load pointer, column and row counters.
// Drives the vector store port and issues tagged matrix words to the MAC.
// Depends on bmvp_pkg.
module bmvp_sequencer import bmvp_pkg::*; #(
  parameter int unsigned MaxLength = 1024,
  parameter int unsigned MaxRows   = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           kind_i,
  input  logic signed [ElemW-1:0]        element_i,
  input  logic                           cfg_we_i,
  input  logic [CfgIdxW-1:0]             cfg_index_i,
  input  logic [CfgW-1:0]                cfg_wdata_i,
  output logic                           mem_we_o,
  output logic                           mem_re_o,
  output logic [$clog2(MaxLength)-1:0]   mem_addr_o,
  output logic signed [ElemW-1:0]        mem_wdata_o,
  output mac_tag_t                       tag_o
);

  localparam int unsigned AddrW  = $clog2(MaxLength);
  localparam int unsigned LenW   = $clog2(MaxLength + 1);
  localparam int unsigned LenCmpW = (LenW > CfgW) ? LenW : CfgW;
  localparam int unsigned RowW   = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned RowsW  = $clog2(MaxRows + 1);
  localparam int unsigned RowCmpW = ((RowsW > CfgW) ? RowsW : CfgW) + 1;

  logic [CfgW-1:0]     len_cfg_q, rows_cfg_q;
  logic [AddrW-1:0]    load_q, load_d;
  logic [AddrW-1:0]    col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [LenCmpW-1:0]  len_eff, len_cfg_x, load_next, col_next;
  logic [RowCmpW-1:0]  rows_eff, rows_cfg_x, row_next;
  logic                row_end, row_last;
  mac_tag_t            tag_q, tag_d;

  // Clamp the register values to the supported range
  always_comb begin
    len_cfg_x  = LenCmpW'(len_cfg_q);
    rows_cfg_x = RowCmpW'(rows_cfg_q);
    if (len_cfg_x == '0) begin
      len_eff = LenCmpW'(1);
    end else if (len_cfg_x > LenCmpW'(MaxLength)) begin
      len_eff = LenCmpW'(MaxLength);
    end else begin
      len_eff = len_cfg_x;
    end
    if (rows_cfg_x == '0) begin
      rows_eff = RowCmpW'(1);
    end else if (rows_cfg_x > RowCmpW'(MaxRows)) begin
      rows_eff = RowCmpW'(MaxRows);
    end else begin
      rows_eff = rows_cfg_x;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q  <= CfgW'(64);
      rows_cfg_q <= CfgW'(64);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VECTOR_LENGTH: len_cfg_q  <= cfg_wdata_i;
        REG_CHANNEL_COUNT: rows_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance pointers and counters for an accepted word
  always_comb begin
    load_next = LenCmpW'(load_q) + LenCmpW'(1);
    col_next  = LenCmpW'(col_q) + LenCmpW'(1);
    row_next  = RowCmpW'(row_q) + RowCmpW'(1);
    row_end   = (col_next >= len_eff);
    row_last  = (row_next >= rows_eff);
    load_d    = load_q;
    col_d     = col_q;
    row_d     = row_q;
    if (accept_i && !kind_i) begin
      load_d = (load_next >= len_eff) ? '0 : AddrW'(load_next);
    end
    if (accept_i && kind_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = row_last ? '0 : RowW'(row_next);
      end else begin
        col_d = AddrW'(col_next);
      end
    end
  end

  // Drive the store port: a load writes, a matrix word reads its column
  always_comb begin
    mem_we_o    = accept_i && !kind_i;
    mem_re_o    = accept_i && kind_i;
    mem_addr_o  = kind_i ? col_q : load_q;
    mem_wdata_o = element_i;
  end

  // Build the tag; it is registered so that it meets the registered read word
  always_comb begin
    tag_d.valid     = accept_i && kind_i;
    tag_d.row_end   = row_end;
    tag_d.last      = row_last;
    tag_d.row_index = RowOutW'(row_q);
    tag_d.element   = element_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      tag_q  <= '0;
    end else begin
      load_q <= load_d;
      col_q  <= col_d;
      row_q  <= row_d;
      tag_q  <= tag_d;
    end
  end

  assign tag_o = tag_q;

  // Tags follow accepted matrix words, the column counter clears at row end and loads leave the row alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q.valid |-> $past(accept_i && kind_i))
    else $error("matrix tag without an accepted matrix word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && kind_i && row_end) |=> (col_q == '0))
    else $error("column counter did not clear at row end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !kind_i) |=> ($stable(col_q) && $stable(row_q)))
    else $error("load disturbed the row in progress");

endmodule

// File: design/bmvp_mac.sv
// MAC pipeline: multiply stage, saturating 48-bit accumulate stage, result register.
// Depends on bmvp_pkg for the tag type and saturation bounds.
module bmvp_mac import bmvp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mac_tag_t                    tag_i,
  input  logic signed [ElemW-1:0]     vec_i,
  output logic                        result_valid_o,
  output logic signed [AccW-1:0]      dot_product_o,
  output logic [RowOutW-1:0]          row_index_o,
  output logic                        last_of_sample_o,
  output logic                        saturated_o
);

  mac_tag_t                tag2_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d, sum_sat;
  logic signed [AccW:0]    sum_wide;
  logic                    clip_q, clip_d, clip_now;
  logic                    valid_q;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= tag_i.element * vec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
    end else begin
      tag2_q <= tag_i;
    end
  end

  // Add and clip to the 48-bit range
  always_comb begin
    sum_wide = $signed({acc_q[AccW-1], acc_q}) + (AccW+1)'(prod_q);
    clip_now = (sum_wide[AccW] != sum_wide[AccW-1]);
    if (!clip_now) begin
      sum_sat = sum_wide[AccW-1:0];
    end else if (sum_wide[AccW]) begin
      sum_sat = ACC_MIN;
    end else begin
      sum_sat = ACC_MAX;
    end
  end

  // Hold the accumulator between words, clear it after a row
  always_comb begin
    acc_d  = acc_q;
    clip_d = clip_q;
    if (tag2_q.valid) begin
      if (tag2_q.row_end) begin
        acc_d  = '0;
        clip_d = 1'b0;
      end else begin
        acc_d  = sum_sat;
        clip_d = clip_q || clip_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      clip_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      clip_q  <= clip_d;
      valid_q <= tag2_q.valid && tag2_q.row_end;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (tag2_q.valid && tag2_q.row_end) begin
      dot_product_o    <= sum_sat;
      row_index_o      <= tag2_q.row_index;
      last_of_sample_o <= tag2_q.last;
      saturated_o      <= clip_q || clip_now;
    end
  end

  assign result_valid_o = valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(tag_i.valid && tag_i.row_end, 2))
    else $error("result word without a row end two stages back");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag2_q.valid && tag2_q.row_end) |=> (acc_q == '0 && !clip_q))
    else $error("accumulator not cleared after row end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tag2_q.valid |=> (acc_q == $past(acc_q) && clip_q == $past(clip_q)))
    else $error("accumulator moved without a matrix word");

endmodule

// File: design/batched_matrix_vector_product.sv
// Top level of the batched matrix-vector product block.
// Depends on bmvp_pkg, bmvp_sequencer, bmvp_vector_store and bmvp_mac.
//
// The block takes one word per clock cycle and never raises busy. A load
// word (kind 0) writes the next vector slot. A matrix word (kind 1) reads its
// column from the single-port vector store, multiplies in the next cycle and
// accumulates in the one after; the row's result word is registered after the
// accumulate stage and shown for one cycle, marked by result_valid_o. The
// receiver cannot hold a result off. The store is not cleared at reset: load a
// vector before streaming a matrix. Configuration is to be written by the user
// only while no word is in flight; the block itself does not enforce this.
module batched_matrix_vector_product import bmvp_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned MAX_ROWS   = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     kind_i,
  input  logic signed [ElemW-1:0]  element_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  output logic                     result_valid_o,
  output logic signed [AccW-1:0]   dot_product_o,
  output logic [RowOutW-1:0]       row_index_o,
  output logic                     last_of_sample_o,
  output logic                     saturated_o
);

  localparam int unsigned AddrW = $clog2(MAX_LENGTH);

  logic                    accept;
  logic                    mem_we, mem_re;
  logic [AddrW-1:0]        mem_addr;
  logic signed [ElemW-1:0] mem_wdata, mem_rdata;
  mac_tag_t                tag;

  // Every cycle can take a word
  assign busy   = 1'b0;
  assign accept = start && !busy;

  bmvp_sequencer #(
    .MaxLength(MAX_LENGTH),
    .MaxRows  (MAX_ROWS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (kind_i),
    .element_i  (element_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .tag_o      (tag)
  );

  bmvp_vector_store #(
    .Depth(MAX_LENGTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  bmvp_mac u_mac (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tag_i           (tag),
    .vec_i           (mem_rdata),
    .result_valid_o  (result_valid_o),
    .dot_product_o   (dot_product_o),
    .row_index_o     (row_index_o),
    .last_of_sample_o(last_of_sample_o),
    .saturated_o     (saturated_o)
  );

endmodule

// File: verif/batched_matrix_vector_product_test.sv
// Self-checking testbench for the batched matrix-vector product block.
// Depends on bmvp_pkg and batched_matrix_vector_product; drives load and matrix
// words, predicts each row sum and checks every result word against it.
`timescale 1ns / 1ps

module batched_matrix_vector_product_test;
  import bmvp_pkg::*;

  localparam int unsigned MAX_LENGTH    = 1024;
  localparam int unsigned MAX_ROWS      = 1024;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned FILL_LEN      = 16;

  // Word kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_MATRIX = 1'b1;

  // Accumulator clip bounds
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  // Random phases: register values, sender idle percentage, word count
  localparam int unsigned PH_LEN   [NUM_PHASES] = '{5, 0, 16, 3, 9, 2};
  localparam int unsigned PH_ROWS  [NUM_PHASES] = '{3, 4, 2047, 1, 1024, 7};
  localparam int unsigned PH_IDLE  [NUM_PHASES] = '{20, 20, 59, 59, 0, 0};
  localparam int unsigned PH_WORDS [NUM_PHASES] = '{130, 100, 130, 100, 140, 140};

  typedef struct packed {
    logic                    kind;
    logic signed [ElemW-1:0] elem;
  } in_word_t;

  typedef struct packed {
    logic signed [AccW-1:0] dot;
    logic [RowOutW-1:0]     row;
    logic                   last;
    logic                   sat;
  } row_sum_t;

  logic                    clk_i;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic                    busy;
  logic                    kind_i      = 1'b0;
  logic signed [ElemW-1:0] element_i   = '0;
  logic                    cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgW-1:0]         cfg_wdata_i = '0;
  logic                    result_valid_o;
  logic signed [AccW-1:0]  dot_product_o;
  logic [RowOutW-1:0]      row_index_o;
  logic                    last_of_sample_o;
  logic                    saturated_o;

  batched_matrix_vector_product dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .element_i        (element_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_o   (result_valid_o),
    .dot_product_o    (dot_product_o),
    .row_index_o      (row_index_o),
    .last_of_sample_o (last_of_sample_o),
    .saturated_o      (saturated_o)
  );

  // Stimulus and expectation stores
  in_word_t    word_q [$];
  row_sum_t    row_sum_q [$];
  int unsigned words_queued  = 0;
  int unsigned words_taken   = 0;
  int unsigned rows_checked  = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned config_writes = 0;
  int unsigned idle_pct      = 0;
  int unsigned stall_cycles  = 0;

  // Shadow of the block: registers, vector store, counters, accumulator
  logic [CfgW-1:0]         len_reg  = 11'd64;
  logic [CfgW-1:0]         rows_reg = 11'd64;
  logic signed [ElemW-1:0] vec_mem [MAX_LENGTH];
  int unsigned             ld_ptr   = 0;
  int unsigned             col_cnt  = 0;
  int unsigned             row_cnt  = 0;
  longint                  acc      = 0;
  logic                    clip     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_count(input logic [CfgW-1:0] v,
                                              input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Extremes often, otherwise any 16-bit value
  function automatic logic signed [ElemW-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(ElemW-1){1'b1}}};
      1: return {1'b1, {(ElemW-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return ElemW'($urandom);
    endcase
  endfunction

  // Advance the shadow by one accepted word and queue the row sum it ends
  task automatic predict_word(input logic kind, input logic signed [ElemW-1:0] elem);
    int unsigned len;
    int unsigned rows;
    int unsigned c;
    longint      sum;
    logic        last;
    row_sum_t    r;
    len  = clamp_count(len_reg, MAX_LENGTH);
    rows = clamp_count(rows_reg, MAX_ROWS);
    if (kind == KIND_LOAD) begin
      c = (ld_ptr >= MAX_LENGTH) ? 0 : ld_ptr;
      vec_mem[c] = elem;
      c++;
      ld_ptr = (c >= len) ? 0 : c;
    end else begin
      c   = (col_cnt >= MAX_LENGTH) ? MAX_LENGTH - 1 : col_cnt;
      sum = acc + longint'(elem) * longint'(vec_mem[c]);
      if (sum > SUM_HI) begin
        sum  = SUM_HI;
        clip = 1'b1;
      end else if (sum < SUM_LO) begin
        sum  = SUM_LO;
        clip = 1'b1;
      end
      acc = sum;
      if (col_cnt + 1 < len) begin
        col_cnt++;
      end else begin
        last   = (row_cnt + 1 >= rows);
        r.dot  = sum[AccW-1:0];
        r.row  = row_cnt[RowOutW-1:0];
        r.last = last;
        r.sat  = clip;
        row_sum_q.push_back(r);
        acc     = 0;
        clip    = 1'b0;
        col_cnt = 0;
        row_cnt = last ? 0 : row_cnt + 1;
      end
    end
  endtask

  // Driver: take the accepted word into the shadow, then present the next one
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    in_word_t w;
    if (!rst_ni) begin
      start     <= 1'b0;
      kind_i    <= KIND_LOAD;
      element_i <= '0;
    end else begin
      if (start && !busy) begin
        predict_word(kind_i, element_i);
        words_taken++;
      end
      if (!start || !busy) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          w = word_q.pop_front();
          start     <= 1'b1;
          kind_i    <= w.kind;
          element_i <= w.elem;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expected row sum
  always @(posedge clk_i) begin : check_rows
    row_sum_t e;
    if (rst_ni && result_valid_o) begin
      if (row_sum_q.size() == 0) begin
        if (mismatch_cnt < MAX_SHOWN)
          $display("unexpected row sum: dot %0d row %0d last %0b sat %0b",
                   dot_product_o, row_index_o, last_of_sample_o, saturated_o);
        mismatch_cnt++;
      end else begin
        e = row_sum_q.pop_front();
        rows_checked++;
        if (dot_product_o !== e.dot || row_index_o !== e.row ||
            last_of_sample_o !== e.last || saturated_o !== e.sat) begin
          if (mismatch_cnt < MAX_SHOWN)
            $display(
              "row sum mismatch: exp dot %0d row %0d last %0b sat %0b / got %0d %0d %0b %0b",
              e.dot, e.row, e.last, e.sat,
              dot_product_o, row_index_o, last_of_sample_o, saturated_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_word(input logic kind, input logic signed [ElemW-1:0] elem);
    in_word_t w;
    w.kind = kind;
    w.elem = elem;
    word_q.push_back(w);
    words_queued++;
  endtask

  // Hold until every word is taken, every row sum is in and the pipe is empty
  task automatic wait_quiet();
    while (words_taken != words_queued) @(posedge clk_i);
    while (row_sum_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back cycles; called just after an edge
  task automatic set_config(input logic [CfgW-1:0] len_val, input logic [CfgW-1:0] rows_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_VECTOR_LENGTH;
    cfg_wdata_i <= len_val;
    @(posedge clk_i);
    cfg_index_i <= REG_CHANNEL_COUNT;
    cfg_wdata_i <= rows_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    len_reg  = len_val;
    rows_reg = rows_val;
    config_writes += 2;
  endtask

  // Mostly whole rows with random content, plus stray loads, reloads and cut rows
  task automatic random_phase(input int unsigned n_words);
    int unsigned len;
    int unsigned made;
    int unsigned pick;
    int unsigned n;
    len  = clamp_count(len_reg, MAX_LENGTH);
    made = 0;
    while (made < n_words) begin
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
        n = $urandom_range(1, 3);
        repeat (n) queue_word(KIND_LOAD, rand_elem());
        made += n;
      end else if (pick < 4) begin
        repeat (len) queue_word(KIND_LOAD, rand_elem());
        made += len;
      end else if (pick < 5) begin
        n = $urandom_range(1, len);
        repeat (n) queue_word(KIND_MATRIX, rand_elem());
        made += n;
      end else begin
        repeat (len) begin
          if ($urandom_range(0, 15) == 0) begin
            queue_word(KIND_LOAD, rand_elem());
            made++;
          end
          queue_word(KIND_MATRIX, rand_elem());
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every slot that later rows can reach, then stream one full row
    set_config(CfgW'(FILL_LEN), 11'd1);
    idle_pct = 20;
    repeat (FILL_LEN) queue_word(KIND_LOAD, rand_elem());
    repeat (FILL_LEN) queue_word(KIND_MATRIX, rand_elem());
    wait_quiet();

    // Directed: element extremes, row wrap and last-of-sample mark
    set_config(11'd3, 11'd2);
    queue_word(KIND_LOAD, 16'sh7FFF);
    queue_word(KIND_LOAD, -16'sh8000);
    queue_word(KIND_LOAD, -16'sh0001);
    queue_word(KIND_MATRIX, -16'sh8000);
    queue_word(KIND_MATRIX, -16'sh8000);
    queue_word(KIND_MATRIX, 16'sh7FFF);
    queue_word(KIND_MATRIX, 16'sh7FFF);
    queue_word(KIND_MATRIX, 16'sh0000);
    queue_word(KIND_MATRIX, -16'sh0001);
    queue_word(KIND_MATRIX, 16'sh0001);
    queue_word(KIND_MATRIX, -16'sh0001);
    queue_word(KIND_MATRIX, 16'sh0100);
    // Leave a row half done and the load pointer mid-vector
    queue_word(KIND_MATRIX, -16'sh8000);
    queue_word(KIND_MATRIX, 16'sh7FFF);
    queue_word(KIND_LOAD, 16'sh0000);
    queue_word(KIND_LOAD, 16'sh00FF);
    wait_quiet();

    // Shrink both registers below the counters; zero clamps up to one
    set_config(11'd0, 11'd0);
    queue_word(KIND_MATRIX, 16'sh7FFF);
    queue_word(KIND_LOAD, -16'sh8000);
    queue_word(KIND_MATRIX, -16'sh0001);
    wait_quiet();

    // Random phases over several register settings and idle rates
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      set_config(CfgW'(PH_LEN[p]), CfgW'(PH_ROWS[p]));
      idle_pct = PH_IDLE[p];
      random_phase(PH_WORDS[p]);
      wait_quiet();
    end

    $display("Ran %0d words through %0d register writes; %0d row sums compared.",
             words_taken, config_writes, rows_checked);
    if (mismatch_cnt == 0 && row_sum_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
